/* hdl/hmi_pkg.sv */
`timescale 1ns / 1ps
// hmi_pkg: shared types and constants for the frame tail parser.
// Used by hmi_tail_frame and hmi_frame_tail_parser; depends on nothing.

package hmi_pkg;

    // Byte counter width covers frame depths up to 255
    localparam int COUNT_W = 8;

    // Tail delimiter FF FC FF FF, newest byte in the low byte
    localparam logic [31:0] TAIL_PATTERN = 32'hFFFC_FFFF;

    // Bytes ahead of the payload (head, screen, widget, type fields)
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 8'd8;

    // Payload length saturates at the largest 7-bit value
    localparam logic [6:0] LEN_MAX = 7'h7F;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_PAYLOAD_LIMIT = 2'd0;
    localparam cfg_index_t REG_BUTTON_CODE   = 2'd1;

    // Configuration reset values
    localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd32;
    localparam logic [7:0] BUTTON_CODE_RESET   = 8'd16;

    // One decoded frame result
    typedef struct packed {
        logic [15:0] screen_id;
        logic [15:0] widget_id;
        logic [7:0]  widget_type;
        logic [7:0]  first_value;
        logic [6:0]  payload_length;
        logic        length_ok;
        logic        is_button;
    } result_t;

    // Per-request status from the frame tracker
    typedef struct packed {
        logic hit;      // tail seen, result produced
        logic overflow; // byte dropped on full frame
    } frame_status_t;

endpackage

/* hdl/hmi_tail_frame.sv */
`timescale 1ns / 1ps
// hmi_tail_frame: frame byte counter, tail window and header capture.
// Uses hmi_pkg types; builds the result for the request taken this cycle.

module hmi_tail_frame
    import hmi_pkg::*;
#(
    parameter int FRAME_DEPTH = 128
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    payload_limit,
    input  logic [7:0]    button_type_code,
    output frame_status_t status,
    output result_t       result
);

    localparam logic [COUNT_W-1:0] DEPTH_LIMIT = COUNT_W'(FRAME_DEPTH);

    // Frame positions of the captured header bytes
    localparam logic [COUNT_W-1:0] POS_SCREEN_HI = 8'd3;
    localparam logic [COUNT_W-1:0] POS_SCREEN_LO = 8'd4;
    localparam logic [COUNT_W-1:0] POS_WIDGET_HI = 8'd5;
    localparam logic [COUNT_W-1:0] POS_WIDGET_LO = 8'd6;
    localparam logic [COUNT_W-1:0] POS_TYPE      = 8'd7;
    localparam logic [COUNT_W-1:0] POS_VALUE     = 8'd8;
    localparam logic [COUNT_W-1:0] TAIL_BYTES    = 8'd4;

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [31:0]        window_reg, window_next;
    logic [15:0]        screen_reg, screen_next;
    logic [15:0]        widget_reg, widget_next;
    logic [7:0]         type_reg,   type_next;
    logic [7:0]         value_reg,  value_next;

    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] len;
    logic               full;
    logic               hit;

    // Capture, shift and tail detect for the incoming byte
    always_comb
    begin
        screen_next = screen_reg;
        widget_next = widget_reg;
        type_next   = type_reg;
        value_next  = value_reg;
        case (count_reg)
            POS_SCREEN_HI: screen_next[15:8] = rx_byte;
            POS_SCREEN_LO: screen_next[7:0]  = rx_byte;
            POS_WIDGET_HI: widget_next[15:8] = rx_byte;
            POS_WIDGET_LO: widget_next[7:0]  = rx_byte;
            POS_TYPE:      type_next         = rx_byte;
            POS_VALUE:     value_next        = rx_byte;
            default:       ;
        endcase
        window_next = {window_reg[23:0], rx_byte};
        cnt         = count_reg + 1'b1;
        full        = (count_reg >= DEPTH_LIMIT);
        hit         = !full && (cnt >= TAIL_BYTES) && (window_next == TAIL_PATTERN);
        count_next  = cnt;
        len         = (cnt >= HEADER_BYTES) ? (cnt - HEADER_BYTES) : '0;
    end

    // Result fields from the updated captures
    always_comb
    begin
        result.screen_id      = screen_next;
        result.widget_id      = widget_next;
        result.widget_type    = type_next;
        result.first_value    = value_next;
        result.payload_length = (len > COUNT_W'(LEN_MAX)) ? LEN_MAX : len[6:0];
        result.length_ok      = (cnt >= HEADER_BYTES) && (len <= payload_limit);
        result.is_button      = (type_next == button_type_code);
        status.hit            = accept && hit;
        status.overflow       = accept && full;
    end

    // Frame state; clears after a tail or a dropped byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            window_reg <= '0;
            screen_reg <= '0;
            widget_reg <= '0;
            type_reg   <= '0;
            value_reg  <= '0;
        end
        else if (accept)
        begin
            if (full || hit)
            begin
                count_reg  <= '0;
                window_reg <= '0;
                screen_reg <= '0;
                widget_reg <= '0;
                type_reg   <= '0;
                value_reg  <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                window_reg <= window_next;
                screen_reg <= screen_next;
                widget_reg <= widget_next;
                type_reg   <= type_next;
                value_reg  <= value_next;
            end
        end
    end

endmodule

/* hdl/hmi_frame_tail_parser.sv */
`timescale 1ns / 1ps
// hmi_frame_tail_parser: tail-delimited serial frame parser, top level.
// A tail result goes to the output register, or to the skid entry under out_stall.
// Throughput: one byte per cycle; the output register plus one skid entry keep
// input accepted while a result waits, in_stall rises only when both are full.
// Reset: frame state and handshake clear; payload_limit 32, button_type_code 16.

module hmi_frame_tail_parser
    import hmi_pkg::*;
#(
    parameter int FRAME_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] screen_id,
    output logic [15:0] widget_id,
    output logic [7:0]  widget_type,
    output logic [7:0]  first_value,
    output logic [6:0]  payload_length,
    output logic        length_ok,
    output logic        is_button,

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]    payload_limit_reg;
    logic [7:0]    button_code_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    result_t       out_res_reg;
    result_t       skid_res_reg;
    result_t       frame_res;
    frame_status_t frame_status;
    logic          in_accept;
    logic          out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_limit_reg <= PAYLOAD_LIMIT_RESET;
            button_code_reg   <= BUTTON_CODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data;
                REG_BUTTON_CODE:   button_code_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    hmi_tail_frame #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .rx_byte          (rx_byte),
        .payload_limit    (payload_limit_reg),
        .button_type_code (button_code_reg),
        .status           (frame_status),
        .result           (frame_res)
    );

    // Output register and skid entry: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || frame_status.hit;
            skid_valid_reg <= 1'b0;
        end
        else if (frame_status.hit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid entry: payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : frame_res;
        end
        else if (frame_status.hit)
        begin
            skid_res_reg <= frame_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign screen_id      = out_res_reg.screen_id;
    assign widget_id      = out_res_reg.widget_id;
    assign widget_type    = out_res_reg.widget_type;
    assign first_value    = out_res_reg.first_value;
    assign payload_length = out_res_reg.payload_length;
    assign length_ok      = out_res_reg.length_ok;
    assign is_button      = out_res_reg.is_button;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a request with the output register empty");

    a_hit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        frame_status.hit |=> out_valid_reg)
        else $error("tail result did not reach the output register");

    a_stalled_hit_skids: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_status.hit && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result produced under output stall was not held in skid");

    a_hit_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(frame_status.hit && frame_status.overflow))
        else $error("dropped byte produced a result");

endmodule

/* dv/hmi_frame_checker.sv */
`timescale 1ns / 1ps
// hmi_frame_checker: watches the byte, result and register channels of the frame
// tail parser, predicts each decoded frame and compares it. Depends on hmi_pkg.

module hmi_frame_checker
    import hmi_pkg::*;
#(
    parameter int FRAME_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] screen_id,
    input  logic [15:0] widget_id,
    input  logic [7:0]  widget_type,
    input  logic [7:0]  first_value,
    input  logic [6:0]  payload_length,
    input  logic        length_ok,
    input  logic        is_button,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [7:0]  cfg_data,

    output int          mismatches,
    output int          outstanding
);

    // Shadow registers
    logic [7:0] limit_shadow;
    logic [7:0] button_shadow;

    // Frame tracking state
    logic [7:0]  frame_count;
    logic [31:0] tail_window;
    logic [15:0] screen_word;
    logic [15:0] widget_word;
    logic [7:0]  type_byte;
    logic [7:0]  value_byte;

    // Decoded frames still waiting on the result channel
    result_t expected_frames[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic clear_frame();
        frame_count = '0;
        tail_window = '0;
        screen_word = '0;
        widget_word = '0;
        type_byte   = '0;
        value_byte  = '0;
    endtask

    // Advance the frame state by one byte; queue a decoded frame on a tail hit
    task automatic track_byte(input logic [7:0] b);
        logic [7:0]  pos;
        int unsigned len;
        result_t     frame;
        pos = frame_count;
        // full frame: byte is dropped and the frame restarts
        if (int'(pos) >= FRAME_DEPTH) begin
            clear_frame();
            return;
        end
        case (pos)
            8'd3: screen_word[15:8] = b;
            8'd4: screen_word[7:0]  = b;
            8'd5: widget_word[15:8] = b;
            8'd6: widget_word[7:0]  = b;
            8'd7: type_byte         = b;
            8'd8: value_byte        = b;
            default: ;
        endcase
        tail_window = {tail_window[23:0], b};
        frame_count = pos + 8'd1;
        if (frame_count >= 8'd4 && tail_window == TAIL_PATTERN) begin
            len = (frame_count >= HEADER_BYTES) ? int'(frame_count - HEADER_BYTES) : 0;
            frame.screen_id      = screen_word;
            frame.widget_id      = widget_word;
            frame.widget_type    = type_byte;
            frame.first_value    = value_byte;
            frame.payload_length = (len > LEN_MAX) ? LEN_MAX : 7'(len);
            frame.length_ok      = (frame_count >= HEADER_BYTES) && (len <= limit_shadow);
            frame.is_button      = (type_byte == button_shadow);
            expected_frames.push_back(frame);
            clear_frame();
        end
    endtask

    // Compare one accepted result with the oldest decoded frame
    task automatic check_result();
        result_t want;
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: screen %h widget %h",
                                      screen_id, widget_id));
            return;
        end
        want = expected_frames.pop_front();
        if (screen_id !== want.screen_id)
            report_mismatch($sformatf("screen_id %h, want %h", screen_id, want.screen_id));
        if (widget_id !== want.widget_id)
            report_mismatch($sformatf("widget_id %h, want %h", widget_id, want.widget_id));
        if (widget_type !== want.widget_type)
            report_mismatch($sformatf("widget_type %h, want %h",
                                      widget_type, want.widget_type));
        if (first_value !== want.first_value)
            report_mismatch($sformatf("first_value %h, want %h",
                                      first_value, want.first_value));
        if (payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, want %0d",
                                      payload_length, want.payload_length));
        if (length_ok !== want.length_ok)
            report_mismatch($sformatf("length_ok %b, want %b", length_ok, want.length_ok));
        if (is_button !== want.is_button)
            report_mismatch($sformatf("is_button %b, want %b", is_button, want.is_button));
    endtask

    // Sample all three channels at each rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_shadow  = PAYLOAD_LIMIT_RESET;
            button_shadow = BUTTON_CODE_RESET;
            clear_frame();
            expected_frames.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PAYLOAD_LIMIT: limit_shadow  = cfg_data;
                    REG_BUTTON_CODE:   button_shadow = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                track_byte(rx_byte);
            outstanding <= expected_frames.size();
        end
    end

endmodule

/* dv/hmi_frame_tail_parser_tb.sv */
`timescale 1ns / 1ps
// hmi_frame_tail_parser_tb: byte stream stimulus and verdict for the frame tail parser.
// Depends on hmi_pkg, hmi_frame_tail_parser and hmi_frame_checker.

module hmi_frame_tail_parser_tb;
    import hmi_pkg::*;

    localparam int FRAME_DEPTH  = 128;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 230;
    localparam int IDLE_PCT     = 7;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] screen_id;
    logic [15:0] widget_id;
    logic [7:0]  widget_type;
    logic [7:0]  first_value;
    logic [6:0]  payload_length;
    logic        length_ok;
    logic        is_button;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index   = REG_PAYLOAD_LIMIT;
    logic [7:0]  cfg_data    = '0;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          in_gap_pct  = IDLE_PCT;
    int          out_stall_pct = IDLE_PCT;
    logic [7:0]  button_code_now = BUTTON_CODE_RESET;

    hmi_frame_tail_parser #(.FRAME_DEPTH(FRAME_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_id(screen_id), .widget_id(widget_id), .widget_type(widget_type),
        .first_value(first_value), .payload_length(payload_length),
        .length_ok(length_ok), .is_button(is_button),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hmi_frame_checker #(.FRAME_DEPTH(FRAME_DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_id(screen_id), .widget_id(widget_id), .widget_type(widget_type),
        .first_value(first_value), .payload_length(payload_length),
        .length_ok(length_ok), .is_button(is_button),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random backpressure on the result side
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One byte request, with random gaps ahead of it
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic push_tail();
        int i;
        for (i = 0; i < 4; i++)
            push_byte(TAIL_PATTERN[31 - 8*i -: 8]);
    endtask

    // Hold off input until every decoded frame has come out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] limit, input logic [7:0] code);
        write_reg(REG_PAYLOAD_LIMIT, limit);
        write_reg(REG_BUTTON_CODE, code);
        cfg_valid <= 1'b0;
        button_code_now = code;
    endtask

    // Head byte, six header bytes (screen and widget ids last), type, first value, body, tail
    task automatic send_frame(input int body_len);
        logic [7:0] kind_byte;
        int i;
        kind_byte = ($urandom_range(0, 1) == 1) ? button_code_now : 8'($urandom);
        push_byte(8'hEE);
        for (i = 0; i < 6; i++)
            push_byte(8'($urandom));
        push_byte(kind_byte);
        push_byte(8'($urandom));
        for (i = 0; i < body_len; i++)
            push_byte(8'($urandom));
        push_tail();
    endtask

    // Mostly well-formed frames; the rest short, overflowing, broken or noise
    task automatic send_random_burst();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 70)
            send_frame($urandom_range(0, 20));
        else if (kind < 78)
            send_frame($urandom_range(21, 115));
        else if (kind < 84) begin
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                push_byte(8'($urandom));
            push_tail();
        end
        else if (kind < 89) begin
            // no 0xFF so no tail forms; frame fills and a byte is dropped
            n = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 12);
            for (i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 254)));
        end
        else if (kind < 95) begin
            push_byte(8'hFF);
            push_byte(8'hFC);
            push_byte(8'hFF);
            push_byte(8'($urandom_range(0, 254)));
        end
        else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                push_byte(8'($urandom));
        end
    endtask

    // Main sequence
    initial begin
        // bare tail; seven-byte frame; complete frame with extreme field values
        logic [7:0] directed_bytes [24] = '{
            8'hFF, 8'hFC, 8'hFF, 8'hFF,
            8'hEE, 8'h00, 8'h00, 8'hFF, 8'hFC, 8'hFF, 8'hFF,
            8'hEE, 8'hB1, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h10, 8'hFF,
            8'hFF, 8'hFC, 8'hFF, 8'hFF
        };
        int i;
        int phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 24; i++)
            push_byte(directed_bytes[i]);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1:       set_config(8'd0, 8'h00);
                    2:       set_config(8'd128, 8'hFF);
                    3:       set_config(8'd4, 8'($urandom));
                    default: set_config(8'($urandom_range(0, 128)), 8'($urandom));
                endcase
            end
            // one phase runs with no gaps and no backpressure
            in_gap_pct    = (phase == 3) ? 0 : IDLE_PCT;
            out_stall_pct = (phase == 3) ? 0 : IDLE_PCT;
            while (bytes_sent < 24 + (phase + 1) * PHASE_BYTES)
                send_random_burst();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/hmi_pkg.sv
hdl/hmi_tail_frame.sv
hdl/hmi_frame_tail_parser.sv
dv/hmi_frame_checker.sv
dv/hmi_frame_tail_parser_tb.sv
